// File: src/mqsb_pkg.sv
package mqsb_pkg;

    localparam int ACTION_W = 1;
    localparam int QID_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_ENQ = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [STATUS_W-1:0]       t_status;
    typedef logic signed [VALUE_W-1:0] t_word;

endpackage

// File: src/mqsb_ifs.sv
interface mqsb_req_if import mqsb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [QID_W-1:0]    queue_id;
    t_word               value;

    modport source (output valid, output action, output queue_id, output value, input ready);
    modport sink   (input valid, input action, input queue_id, input value, output ready);
endinterface

interface mqsb_rsp_if import mqsb_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_word   data_out;

    modport source (output valid, output status, output data_out, input ready);
    modport sink   (input valid, input status, input data_out, output ready);
endinterface

// File: src/multi_queue_shared_buffer.sv
// Up to NUM_QUEUES FIFO queues share one store of CAPACITY data slots. A link
// table chains the slots of every queue and of the free list. The block takes
// one request beat at a time: ready is high only while it is idle. A request
// that succeeds passes the read, link and write-back states before its result
// beat is loaded; one that answers full or empty, as does an out-of-range
// queue, is answered from the read state. Each update reads the link table
// and the head/tail table before it writes them. A waiting result beat holds
// the next request back only when the block itself has a new result to load.
// The link table needs no clearing pass after reset: a fill mark stands in
// for its reset contents, so the block is ready as soon as reset is released.
module multi_queue_shared_buffer import mqsb_pkg::*; #(
    parameter int NUM_QUEUES = 8,
    parameter int CAPACITY   = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mqsb_req_if.sink   i_req,
    mqsb_rsp_if.source o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_LK   = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [ACTION_W-1:0] r_act;
    logic [QID_W-1:0]    r_qid;
    t_word               r_value;
    logic [PW-1:0]       r_free_head, n_free_head;
    logic [AW-1:0]       r_slot, n_slot;
    logic [NUM_QUEUES-1:0] r_qne;
    logic [2*AW-1:0]     r_queue_mem [NUM_QUEUES];
    logic [2*AW-1:0]     r_qrow;
    t_word               r_data_mem [CAPACITY];
    t_word               r_drd;
    logic                r_ovalid, n_ovalid;
    t_status             r_ostatus;
    t_word               r_odata;

    logic [QW-1:0] w_qidx;
    logic          w_qok, w_qne, w_out_free;
    logic [AW-1:0] w_head, w_tail;
    logic          lk_re, lk_we;
    logic [AW-1:0] lk_raddr, lk_waddr;
    logic [PW-1:0] lk_wdata, lk_rdata;
    logic          q_re, q_we, qne_set, qne_clr, d_we, d_re;
    logic [2*AW-1:0] q_wrow;
    logic          out_load;
    t_status       out_status;
    t_word         out_data;

    assign w_qidx     = QW'(r_qid);
    assign w_qok      = (int'(r_qid) < NUM_QUEUES);
    assign w_qne      = w_qok && r_qne[w_qidx];
    assign w_head     = r_qrow[2*AW-1:AW];
    assign w_tail     = r_qrow[AW-1:0];
    assign w_out_free = !r_ovalid || o_rsp.ready;

    mqsb_link_store #(.CAPACITY(CAPACITY)) u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (lk_re),
        .i_raddr (lk_raddr),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .o_rdata (lk_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_slot      = r_slot;
        lk_re       = 1'b0;
        lk_raddr    = r_free_head[AW-1:0];
        lk_we       = 1'b0;
        lk_waddr    = r_slot;
        lk_wdata    = NIL;
        q_re        = 1'b0;
        q_we        = 1'b0;
        q_wrow      = r_qrow;
        qne_set     = 1'b0;
        qne_clr     = 1'b0;
        d_we        = 1'b0;
        d_re        = 1'b0;
        out_load    = 1'b0;
        out_status  = ST_DONE;
        out_data    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_act == ACT_ENQ) begin
                    if (!w_qok || (r_free_head == NIL)) begin
                        out_status = ST_FULL;
                        if (w_out_free) begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end else begin
                        q_re    = 1'b1;
                        lk_re   = 1'b1;
                        n_slot  = r_free_head[AW-1:0];
                        n_state = S_LK;
                    end
                end else begin
                    if (!w_qne) begin
                        out_status = ST_EMPTY;
                        if (w_out_free) begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end else begin
                        q_re    = 1'b1;
                        n_state = S_LK;
                    end
                end
            end
            S_LK: begin
                if (r_act == ACT_ENQ) begin
                    d_we        = 1'b1;
                    lk_we       = 1'b1;
                    lk_waddr    = r_slot;
                    lk_wdata    = NIL;
                    n_free_head = lk_rdata;
                end else begin
                    n_slot   = w_head;
                    lk_re    = 1'b1;
                    lk_raddr = w_head;
                    d_re     = 1'b1;
                end
                n_state = S_WB;
            end
            S_WB: begin
                if (w_out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (r_act == ACT_ENQ) begin
                        if (w_qne) begin
                            lk_we    = 1'b1;
                            lk_waddr = w_tail;
                            lk_wdata = PW'(r_slot);
                        end
                        q_we    = 1'b1;
                        q_wrow  = {(w_qne ? w_head : r_slot), r_slot};
                        qne_set = 1'b1;
                    end else begin
                        lk_we       = 1'b1;
                        lk_waddr    = r_slot;
                        lk_wdata    = r_free_head;
                        n_free_head = PW'(r_slot);
                        if (lk_rdata == NIL) begin
                            qne_clr = 1'b1;
                        end else begin
                            q_we   = 1'b1;
                            q_wrow = {lk_rdata[AW-1:0], w_tail};
                        end
                        out_data = r_drd;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_ovalid = (r_ovalid && !o_rsp.ready) || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_qne       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_ovalid    <= n_ovalid;
            if (qne_set) begin
                r_qne[w_qidx] <= 1'b1;
            end else if (qne_clr) begin
                r_qne[w_qidx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_req.valid) begin
            r_act   <= i_req.action;
            r_qid   <= i_req.queue_id;
            r_value <= i_req.value;
        end
        r_slot <= n_slot;
        if (out_load) begin
            r_ostatus <= out_status;
            r_odata   <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue_mem[w_qidx] <= q_wrow;
        end
        if (q_re) begin
            r_qrow <= r_queue_mem[w_qidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_data_mem[r_slot] <= r_value;
        end
        if (d_re) begin
            r_drd <= r_data_mem[w_head];
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.status   = r_ostatus;
    assign o_rsp.data_out = r_odata;

endmodule

// File: src/mqsb_link_store.sv
module mqsb_link_store import mqsb_pkg::*; #(
    parameter int CAPACITY = 64,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int PW = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [PW-1:0] i_wdata,
    output logic [PW-1:0] o_rdata
);

    // Slots at or above the fill mark were never written and still hold
    // their reset link to the next slot.
    logic [PW-1:0] r_mem [CAPACITY];
    logic [PW-1:0] r_fill;
    logic [PW-1:0] n_fill;
    logic [PW-1:0] r_rd_mem;
    logic [PW-1:0] r_rd_seq;
    logic          r_rd_fresh;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_mem   <= r_mem[i_raddr];
            r_rd_fresh <= (PW'(i_raddr) >= r_fill);
            r_rd_seq   <= PW'(i_raddr) + PW'(1);
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_we && (PW'(i_waddr) == r_fill)) begin
            n_fill = r_fill + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_rdata = r_rd_fresh ? r_rd_seq : r_rd_mem;

endmodule

// File: src/mqsb_checker.sv
module mqsb_checker import mqsb_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_req_valid,
    input logic    i_req_ready,
    input logic    i_rsp_valid,
    input logic    i_rsp_ready,
    input t_status i_rsp_status,
    input t_word   i_rsp_data_out
);

    // The block works on one request beat at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another is in flight");

    // No result beat can appear in the cycle right after a request beat.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !$rose(i_rsp_valid))
        else $error("result beat appeared too early");

    // A failed request always returns a zero data word.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != ST_DONE)) |-> (i_rsp_data_out == '0))
        else $error("failed request returned nonzero data");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_data_out)))
        else $error("stalled result beat changed");

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_data_out (o_rsp.data_out)
);
